[rtl/glas_pkg.sv]
// Shared constants, codes and the arctangent table of the gimbal linkage angle solver.
package glas_pkg;

  localparam int unsigned CordicSteps   = 17;
  localparam int unsigned TwoPiQ16      = 411775;
  localparam int unsigned PiQ16         = 205887;
  localparam int unsigned HalfPiQ16     = 102944;
  localparam int unsigned CordicGainQ30 = 652032874;

  localparam int unsigned CfgDataWidth  = 32;
  localparam int unsigned CfgIdxWidth   = 3;

  typedef enum logic [1:0] {
    StatusOk      = 2'd0,
    StatusNegDisc = 2'd1,
    StatusZeroDen = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    RegLinkA = 3'd0,
    RegLinkB = 3'd1,
    RegLinkC = 3'd2,
    RegLinkD = 3'd3,
    RegLinkE = 3'd4
  } cfg_reg_e;

  // atan(2^-i) in Q.16
  function automatic logic [16:0] atan_q16(input int unsigned idx);
    logic [16:0] val;
    case (idx)
      0:       val = 17'd51472;
      1:       val = 17'd30386;
      2:       val = 17'd16055;
      3:       val = 17'd8150;
      4:       val = 17'd4091;
      5:       val = 17'd2047;
      6:       val = 17'd1024;
      7:       val = 17'd512;
      8:       val = 17'd256;
      9:       val = 17'd128;
      10:      val = 17'd64;
      11:      val = 17'd32;
      12:      val = 17'd16;
      13:      val = 17'd8;
      14:      val = 17'd4;
      15:      val = 17'd2;
      16:      val = 17'd1;
      default: val = 17'd0;
    endcase
    return val;
  endfunction

endpackage

[rtl/glas_cossin.sv]
// Pipelined angle reduction and rotation CORDIC giving cosine and sine in Q.30.
module glas_cossin #(
  parameter int AngleWidth = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic signed [AngleWidth-1:0] angle_i,
  output logic                         valid_o,
  output logic signed [32:0]           cos_o,
  output logic signed [32:0]           sin_o
);

  localparam int SW       = AngleWidth + 4;
  localparam int RedSteps = (AngleWidth > 15) ? AngleWidth - 14 : 1;
  localparam int RW       = (SW + 2 > 20) ? SW + 2 : 20;
  localparam int ZW       = 21;
  localparam int XW       = 33;
  localparam int NS       = glas_pkg::CordicSteps;

  localparam logic signed [ZW-1:0] TwoPi  = ZW'(glas_pkg::TwoPiQ16);
  localparam logic signed [ZW-1:0] Pi     = ZW'(glas_pkg::PiQ16);
  localparam logic signed [ZW-1:0] HalfPi = ZW'(glas_pkg::HalfPiQ16);

  logic                   vin_q;
  logic                   neg_q;
  logic [SW-1:0]          mag_q;
  logic signed [SW-1:0]   ang_scaled;

  logic                   rv_q   [RedSteps];
  logic                   rneg_q [RedSteps];
  logic [SW-1:0]          red_q  [RedSteps];

  logic                   cv_q   [NS+1];
  logic                   flip_q [NS+1];
  logic signed [XW-1:0]   x_q    [NS+1];
  logic signed [XW-1:0]   y_q    [NS+1];
  logic signed [ZW-1:0]   z_q    [NS+1];

  logic                   ov_q;
  logic signed [XW-1:0]   cos_q, sin_q;

  logic [RW-1:0]          red_ext;
  logic signed [ZW-1:0]   r0, r1, r2;
  logic                   flip_d;

  assign ang_scaled = {angle_i, 4'b0000};

  // input stage: split sign and magnitude so the remainder truncates toward zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vin_q <= 1'b0;
    end else begin
      vin_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= ang_scaled[SW-1];
    mag_q <= ang_scaled[SW-1] ? SW'(-ang_scaled) : SW'(ang_scaled);
  end

  // restoring reduction modulo 2*pi, one multiple per stage
  for (genvar g = 0; g < RedSteps; g++) begin : g_red
    localparam logic [RW-1:0] Sub = RW'(glas_pkg::TwoPiQ16) << (RedSteps - 1 - g);
    logic          vin;
    logic          nin;
    logic [SW-1:0] rin;
    logic [RW-1:0] rin_ext;

    if (g == 0) begin : g_first
      assign vin = vin_q;
      assign nin = neg_q;
      assign rin = mag_q;
    end else begin : g_next
      assign vin = rv_q[g-1];
      assign nin = rneg_q[g-1];
      assign rin = red_q[g-1];
    end

    assign rin_ext = RW'(rin);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rv_q[g] <= 1'b0;
      end else begin
        rv_q[g] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      rneg_q[g] <= nin;
      red_q[g]  <= (rin_ext >= Sub) ? SW'(rin_ext - Sub) : rin;
    end
  end

  // fold into [-pi/2, pi/2]
  assign red_ext = RW'(red_q[RedSteps-1]);

  always_comb begin
    r0 = rneg_q[RedSteps-1] ? -ZW'({2'b00, red_ext[18:0]}) : ZW'({2'b00, red_ext[18:0]});
    if (r0 > Pi) begin
      r1 = r0 - TwoPi;
    end else if (r0 < -Pi) begin
      r1 = r0 + TwoPi;
    end else begin
      r1 = r0;
    end
    flip_d = 1'b0;
    if (r1 > HalfPi) begin
      r2     = r1 - Pi;
      flip_d = 1'b1;
    end else if (r1 < -HalfPi) begin
      r2     = r1 + Pi;
      flip_d = 1'b1;
    end else begin
      r2 = r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q[0] <= 1'b0;
    end else begin
      cv_q[0] <= rv_q[RedSteps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    flip_q[0] <= flip_d;
    x_q[0]    <= XW'(glas_pkg::CordicGainQ30);
    y_q[0]    <= '0;
    z_q[0]    <= r2;
  end

  // rotation CORDIC, one micro-rotation per stage
  for (genvar i = 0; i < NS; i++) begin : g_rot
    localparam logic signed [ZW-1:0] Atan = ZW'(glas_pkg::atan_q16(i));
    logic signed [XW-1:0] xs, ys;

    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_q[i+1] <= 1'b0;
      end else begin
        cv_q[i+1] <= cv_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      flip_q[i+1] <= flip_q[i];
      if (!z_q[i][ZW-1]) begin
        x_q[i+1] <= x_q[i] - ys;
        y_q[i+1] <= y_q[i] + xs;
        z_q[i+1] <= z_q[i] - Atan;
      end else begin
        x_q[i+1] <= x_q[i] + ys;
        y_q[i+1] <= y_q[i] - xs;
        z_q[i+1] <= z_q[i] + Atan;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else begin
      ov_q <= cv_q[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    cos_q <= flip_q[NS] ? -x_q[NS] : x_q[NS];
    sin_q <= flip_q[NS] ? -y_q[NS] : y_q[NS];
  end

  assign valid_o = ov_q;
  assign cos_o   = cos_q;
  assign sin_o   = sin_q;

  a_mag_top_only_min : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vin_q && mag_q[SW-1] |-> neg_q)
    else $error("scaled magnitude top bit set for a non-negative angle");

  a_red_below_two_pi : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_q[RedSteps-1] |-> (RW'(red_q[RedSteps-1]) < RW'(glas_pkg::TwoPiQ16)))
    else $error("angle reduction left a remainder of 2*pi or more");

  a_fold_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cv_q[0] |-> (z_q[0] <= HalfPi) && (z_q[0] >= -HalfPi))
    else $error("folded angle outside [-pi/2, pi/2]");

endmodule

[rtl/gimbal_linkage_angle_solver_core.sv]
// Top level of the gimbal linkage angle solver: fully pipelined half-angle closed form.
//
// Usage:
//   Write the five linkage registers (a, b, c, d, e; signed Q16.16) through the
//   plain write port: cfg_we_i, cfg_idx_i (0..4, other indexes are ignored) and
//   cfg_wdata_i. Change them only while no item is in flight.
//   Issue an item by raising start with servo_angle_i and tilt_angle_i (signed
//   Q3.12 radians). busy stays low: the pipeline takes one item every cycle.
//   Each item gives one result: done_o pulses for one cycle with gimbal_angle_o
//   (Q3.12, zero on error) and status_o (ok, negative discriminant, zero
//   denominator). Results leave in issue order.
// Depth: set by the bit-serial angle reduction (RS stages with RS =
//   max(1, ANGLE_WIDTH - 14)), two 17-stage CORDICs and the 31-stage square
//   root, one step each.
// Throughput: one item per clock cycle, sustained.
// Reset: clears all valid bits and the linkage registers to zero; data in the
//   pipe is dropped. The receiver cannot stall, so no back pressure exists.
module gimbal_linkage_angle_solver_core #(
  parameter int ANGLE_WIDTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [ANGLE_WIDTH-1:0]          servo_angle_i,
  input  logic signed [ANGLE_WIDTH-1:0]          tilt_angle_i,
  input  logic                                   cfg_we_i,
  input  logic [glas_pkg::CfgIdxWidth-1:0]       cfg_idx_i,
  input  logic [glas_pkg::CfgDataWidth-1:0]      cfg_wdata_i,
  output logic                                   done_o,
  output logic signed [ANGLE_WIDTH-1:0]          gimbal_angle_o,
  output logic [1:0]                             status_o
);

  localparam int PW      = 34;   // p, q and c*cos(t)
  localparam int MW      = 68;   // raw products
  localparam int UW      = 54;   // u, v, w before normalizing
  localparam int LW      = $clog2(UW);
  localparam int NW      = 31;   // normalized u, v, w
  localparam int SQW     = 62;   // square-root remainder
  localparam int RTW     = 31;   // square root
  localparam int DW      = 32;   // denominator
  localparam int XW      = 36;   // vectoring CORDIC x, y
  localparam int ZW      = 20;   // vectoring CORDIC angle
  localparam int GW      = 22;
  localparam int SatW    = (ANGLE_WIDTH > GW) ? ANGLE_WIDTH + 1 : GW + 1;
  localparam int NS      = glas_pkg::CordicSteps;
  localparam int NStages = 61;

  localparam logic [LW-1:0] NormLo = LW'(29);
  localparam logic [LW-1:0] NormHi = LW'(30);
  localparam logic signed [SatW-1:0] GMax = SatW'((64'sd1 <<< (ANGLE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [SatW-1:0] GMin = -GMax - SatW'(1);

  // linkage registers
  logic signed [31:0] link_a_q, link_b_q, link_c_q, link_d_q, link_e_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_a_q <= '0;
      link_b_q <= '0;
      link_c_q <= '0;
      link_d_q <= '0;
      link_e_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        glas_pkg::RegLinkA: link_a_q <= cfg_wdata_i;
        glas_pkg::RegLinkB: link_b_q <= cfg_wdata_i;
        glas_pkg::RegLinkC: link_c_q <= cfg_wdata_i;
        glas_pkg::RegLinkD: link_d_q <= cfg_wdata_i;
        glas_pkg::RegLinkE: link_e_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // accept every cycle: the pipe never stalls
  assign busy = 1'b0;

  logic                 cs_valid;
  logic signed [32:0]   cos_s, sin_s, cos_t;

  glas_cossin #(.AngleWidth(ANGLE_WIDTH)) u_servo_cossin (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start & ~busy),
    .angle_i (servo_angle_i),
    .valid_o (cs_valid),
    .cos_o   (cos_s),
    .sin_o   (sin_s)
  );

  glas_cossin #(.AngleWidth(ANGLE_WIDTH)) u_tilt_cossin (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start & ~busy),
    .angle_i (tilt_angle_i),
    .valid_o (),
    .cos_o   (cos_t),
    .sin_o   ()
  );

  // valid bits, one per stage after the cosine/sine units
  logic vld_q [NStages];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NStages; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else begin
      vld_q[0] <= cs_valid;
      for (int k = 1; k < NStages; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // stage 1: products with the trig values
  logic signed [64:0] pa_q, pb_q, pc_q;
  // stage 2: p, q, c*cos(t)
  logic signed [PW-1:0] p_q, q_q, cct_q;
  // stage 3: squares and cross products
  logic signed [MW-1:0] pp_q, qq_q, bb_q, cc_q, cp_q, vq_q;
  // stage 4: partial sums
  logic signed [UW-1:0] s1_q, s2_q, v4_q, w4_q;
  // stage 5: u, v, w
  logic signed [UW-1:0] u5_q, v5_q, w5_q;
  // stage 6: magnitudes
  logic signed [UW-1:0] u6_q, v6_q, w6_q;
  logic [UW-1:0]        mu_q, mv_q, mw_q;
  // stage 7: largest magnitude
  logic signed [UW-1:0] u7_q, v7_q, w7_q;
  logic [UW-1:0]        m_q;
  // stage 8: leading one
  logic signed [UW-1:0] u8_q, v8_q, w8_q;
  logic [LW-1:0]        lead_q;
  logic                 mz_q;
  // stage 9: normalized values
  logic signed [NW-1:0] nu_q, nv_q, nw_q;
  // stage 10: squares and denominator
  logic signed [2*NW-1:0] uu_q, vv_q, ww_q;
  logic signed [NW-1:0]   nv10_q;
  logic signed [DW-1:0]   den10_q;

  logic [UW-1:0]        m_d;
  logic [LW-1:0]        lead_d;
  logic signed [UW-1:0] un_d, vn_d, wn_d;
  logic [LW-1:0]        shamt;

  always_comb begin
    m_d = mu_q;
    if (mv_q > m_d) begin
      m_d = mv_q;
    end
    if (mw_q > m_d) begin
      m_d = mw_q;
    end
  end

  always_comb begin
    lead_d = '0;
    for (int j = 0; j < UW; j++) begin
      if (m_q[j]) begin
        lead_d = LW'(j);
      end
    end
  end

  always_comb begin
    shamt = '0;
    un_d  = u8_q;
    vn_d  = v8_q;
    wn_d  = w8_q;
    if (lead_q >= NormHi) begin
      shamt = lead_q - NormLo;
      un_d  = u8_q >>> shamt;
      vn_d  = v8_q >>> shamt;
      wn_d  = w8_q >>> shamt;
    end else if (!mz_q && lead_q < NormLo) begin
      shamt = NormLo - lead_q;
      un_d  = u8_q <<< shamt;
      vn_d  = v8_q <<< shamt;
      wn_d  = w8_q <<< shamt;
    end
  end

  always_ff @(posedge clk_i) begin
    // stage 1
    pa_q <= link_a_q * cos_s;
    pb_q <= link_a_q * sin_s;
    pc_q <= link_c_q * cos_t;
    // stage 2
    p_q   <= PW'(link_d_q) + PW'(pa_q >>> 30);
    q_q   <= PW'(link_e_q) - PW'(pb_q >>> 30);
    cct_q <= PW'(pc_q >>> 30);
    // stage 3
    pp_q <= p_q * p_q;
    qq_q <= q_q * q_q;
    bb_q <= MW'(link_b_q) * MW'(link_b_q);
    cc_q <= MW'(link_c_q) * MW'(link_c_q);
    cp_q <= MW'(link_c_q) * MW'(p_q);
    vq_q <= cct_q * q_q;
    // stage 4
    s1_q <= UW'(bb_q >>> 16) - UW'(cc_q >>> 16);
    s2_q <= UW'(pp_q >>> 16) + UW'(qq_q >>> 16);
    v4_q <= UW'(vq_q >>> 16) <<< 1;
    w4_q <= -(UW'(cp_q >>> 16) <<< 1);
    // stage 5
    u5_q <= s1_q - s2_q;
    v5_q <= v4_q;
    w5_q <= w4_q;
    // stage 6
    u6_q <= u5_q;
    v6_q <= v5_q;
    w6_q <= w5_q;
    mu_q <= u5_q[UW-1] ? UW'(-u5_q) : UW'(u5_q);
    mv_q <= v5_q[UW-1] ? UW'(-v5_q) : UW'(v5_q);
    mw_q <= w5_q[UW-1] ? UW'(-w5_q) : UW'(w5_q);
    // stage 7
    u7_q <= u6_q;
    v7_q <= v6_q;
    w7_q <= w6_q;
    m_q  <= m_d;
    // stage 8
    u8_q   <= u7_q;
    v8_q   <= v7_q;
    w8_q   <= w7_q;
    lead_q <= lead_d;
    mz_q   <= (m_q == '0);
    // stage 9
    nu_q <= un_d[NW-1:0];
    nv_q <= vn_d[NW-1:0];
    nw_q <= wn_d[NW-1:0];
    // stage 10
    uu_q    <= nu_q * nu_q;
    vv_q    <= nv_q * nv_q;
    ww_q    <= nw_q * nw_q;
    nv10_q  <= nv_q;
    den10_q <= DW'(nu_q) + DW'(nw_q);
  end

  // stage 11: discriminant, status, then the square root one bit per stage
  logic [SQW-1:0]          sq_rem_q  [RTW+1];
  logic [RTW-1:0]          sq_root_q [RTW+1];
  logic signed [NW-1:0]    sq_nv_q   [RTW+1];
  logic signed [DW-1:0]    sq_den_q  [RTW+1];
  glas_pkg::status_e       sq_st_q   [RTW+1];

  logic signed [2*NW:0]    disc_d;
  glas_pkg::status_e       st_d;

  always_comb begin
    disc_d = (2*NW+1)'(ww_q) + (2*NW+1)'(vv_q) - (2*NW+1)'(uu_q);
    if (disc_d[2*NW]) begin
      st_d = glas_pkg::StatusNegDisc;
    end else if (den10_q == '0) begin
      st_d = glas_pkg::StatusZeroDen;
    end else begin
      st_d = glas_pkg::StatusOk;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_rem_q[0]  <= disc_d[SQW-1:0];
    sq_root_q[0] <= '0;
    sq_nv_q[0]   <= nv10_q;
    sq_den_q[0]  <= den10_q;
    sq_st_q[0]   <= st_d;
  end

  for (genvar j = 0; j < RTW; j++) begin : g_sqrt
    localparam int Bit = RTW - 1 - j;
    logic [SQW-1:0] trial;

    assign trial = (SQW'(sq_root_q[j]) << (Bit + 1)) | (SQW'(1) << (2 * Bit));

    always_ff @(posedge clk_i) begin
      sq_nv_q[j+1]  <= sq_nv_q[j];
      sq_den_q[j+1] <= sq_den_q[j];
      sq_st_q[j+1]  <= sq_st_q[j];
      if (sq_rem_q[j] >= trial) begin
        sq_rem_q[j+1]  <= sq_rem_q[j] - trial;
        sq_root_q[j+1] <= sq_root_q[j] | (RTW'(1) << Bit);
      end else begin
        sq_rem_q[j+1]  <= sq_rem_q[j];
        sq_root_q[j+1] <= sq_root_q[j];
      end
    end
  end

  // numerator, sign fix, then the vectoring CORDIC
  logic signed [XW-1:0]  cx_q  [NS+1];
  logic signed [XW-1:0]  cy_q  [NS+1];
  logic signed [ZW-1:0]  cz_q  [NS+1];
  glas_pkg::status_e     cst_q [NS+1];

  logic signed [XW-1:0]  num_d, den_d;

  assign num_d = XW'(sq_nv_q[RTW]) - XW'({1'b0, sq_root_q[RTW]});
  assign den_d = XW'(sq_den_q[RTW]);

  always_ff @(posedge clk_i) begin
    cx_q[0]  <= den_d[XW-1] ? -den_d : den_d;
    cy_q[0]  <= den_d[XW-1] ? -num_d : num_d;
    cz_q[0]  <= '0;
    cst_q[0] <= sq_st_q[RTW];
  end

  for (genvar i = 0; i < NS; i++) begin : g_vec
    localparam logic signed [ZW-1:0] Atan = ZW'(glas_pkg::atan_q16(i));
    logic signed [XW-1:0] xs, ys;

    assign xs = cx_q[i] >>> i;
    assign ys = cy_q[i] >>> i;

    always_ff @(posedge clk_i) begin
      cst_q[i+1] <= cst_q[i];
      if (!cy_q[i][XW-1]) begin
        cx_q[i+1] <= cx_q[i] + ys;
        cy_q[i+1] <= cy_q[i] - xs;
        cz_q[i+1] <= cz_q[i] + Atan;
      end else begin
        cx_q[i+1] <= cx_q[i] - ys;
        cy_q[i+1] <= cy_q[i] + xs;
        cz_q[i+1] <= cz_q[i] - Atan;
      end
    end
  end

  // output stage: double, round to Q.12, saturate, zero on error
  logic signed [GW-1:0]          g_d;
  logic signed [SatW-1:0]        gs_d;
  logic signed [ANGLE_WIDTH-1:0] angle_d;
  logic signed [ANGLE_WIDTH-1:0] angle_q;
  glas_pkg::status_e             status_q;

  always_comb begin
    g_d  = ((GW'(cz_q[NS]) <<< 1) + GW'(8)) >>> 4;
    gs_d = SatW'(g_d);
    if (gs_d > GMax) begin
      gs_d = GMax;
    end else if (gs_d < GMin) begin
      gs_d = GMin;
    end
    angle_d = (cst_q[NS] == glas_pkg::StatusOk) ? ANGLE_WIDTH'(gs_d) : '0;
  end

  always_ff @(posedge clk_i) begin
    angle_q  <= angle_d;
    status_q <= cst_q[NS];
  end

  assign done_o         = vld_q[NStages-1];
  assign gimbal_angle_o = angle_q;
  assign status_o       = status_q;

  a_error_zero_angle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != glas_pkg::StatusOk) |-> (gimbal_angle_o == '0))
    else $error("nonzero angle on an error result");

  a_sqrt_floor : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[10 + RTW] && (sq_st_q[RTW] == glas_pkg::StatusOk)
      |-> (sq_rem_q[RTW] <= (SQW'(sq_root_q[RTW]) << 1)))
    else $error("square root is not the floor root");

  a_vec_x_nonneg : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[11 + RTW] |-> !cx_q[0][XW-1])
    else $error("vectoring CORDIC started with negative x");

endmodule
